### rtl/ideal_mhd_flux_2d_assert.svh
// Assertion macros for the ideal MHD flux block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef IDEAL_MHD_FLUX_2D_ASSERT_SVH
`define IDEAL_MHD_FLUX_2D_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check that is ignored while reset is asserted.
`define IMHD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Clocked check that holds in every cycle, reset included.
`define IMHD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define IMHD_ASSERT(lbl, clk, rst_n, prop)
`define IMHD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### rtl/imhd_pkg.sv
// Shared types, constants and fixed-point helpers for the ideal MHD flux block.
// No dependencies; used by imhd_div and ideal_mhd_flux_2d.
`timescale 1ns / 1ps

package imhd_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QUO_BITS      = 32;
    localparam int DIV_STEPS     = 4;

    localparam logic [17:0] GAMMA_RESET = 18'd109227;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NONPOS = 2'd1;
    localparam logic [1:0] ST_SAT    = 2'd2;

    localparam logic DIR_X = 1'b0;
    localparam logic DIR_Y = 1'b1;

    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [63:0] Q_MAX64 = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN64 = -64'sd2147483648;

    // A fixed-point value together with its saturation flag.
    typedef struct packed {
        logic              sat;
        logic signed [31:0] v;
    } t_qs;

    // Per-point values that travel beside the divider and the arithmetic stages.
    typedef struct packed {
        logic signed [31:0] rho;
        logic signed [31:0] energy;
        logic signed [31:0] b1;
        logic signed [31:0] b2;
        logic signed [31:0] b3;
        logic               nonpos;
    } t_side;

    // Flux components of both directions, mass flux in element 0.
    typedef struct packed {
        logic [7:0][31:0] fy;
        logic [7:0][31:0] fx;
    } t_flux;

    // Clamp a wide value to the signed 32-bit range.
    function automatic t_qs f_sat64(input logic signed [63:0] x);
        t_qs r;
        if (x > Q_MAX64) begin
            r.sat = 1'b1;
            r.v   = Q_MAX;
        end else if (x < Q_MIN64) begin
            r.sat = 1'b1;
            r.v   = Q_MIN;
        end else begin
            r.sat = 1'b0;
            r.v   = x[31:0];
        end
        return r;
    endfunction

    // Product scaled back by the fraction width, rounded toward minus infinity.
    function automatic t_qs f_mul(input logic signed [31:0] a,
                                  input logic signed [31:0] b,
                                  input int frac);
        logic signed [63:0] p;
        p = a * b;
        p = p >>> frac;
        return f_sat64(p);
    endfunction

    function automatic t_qs f_add(input logic signed [31:0] a,
                                  input logic signed [31:0] b);
        logic signed [32:0] s;
        t_qs r;
        s = {a[31], a} + {b[31], b};
        r.sat = (s[32] != s[31]);
        r.v   = r.sat ? (s[32] ? Q_MIN : Q_MAX) : s[31:0];
        return r;
    endfunction

    function automatic t_qs f_sub(input logic signed [31:0] a,
                                  input logic signed [31:0] b);
        logic signed [32:0] s;
        t_qs r;
        s = {a[31], a} - {b[31], b};
        r.sat = (s[32] != s[31]);
        r.v   = r.sat ? (s[32] ? Q_MIN : Q_MAX) : s[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] f_half(input logic signed [31:0] a);
        return a >>> 1;
    endfunction

endpackage

### rtl/ideal_mhd_flux_2d.sv
// Top level of the two-dimensional ideal MHD flux pipeline.
// Depends on imhd_pkg, imhd_div and the macros in ideal_mhd_flux_2d_assert.svh.
//
// Usage: one grid point (density, three momenta, total energy, three field
// components) enters on the s_ stream as one transfer. For each point the
// m_ stream delivers two transfers: first the eight x-direction fluxes
// (tuser direction 0), then the eight y-direction fluxes (direction 1, tlast
// high). tuser also carries the status: ok, nonpositive density, or a value
// saturated somewhere in the point's arithmetic.
// The x result passes the divider input register, the divider stages, stages
// A to H and the output register; the y result follows in the cycle after
// the x result is taken. Each point needs two output transfers, so no new
// point moves on while the output stage holds one whose y result is not taken;
// the 8-stage divider and stages A to H take a new point every cycle while the output stage is free.
// Reset clears all stage valid bits, the output phase and gas_gamma (to five
// thirds). When the receiver stalls, the whole pipeline and s_tready hold, so
// no point is lost or repeated. gas_gamma is written through the APB port.
`timescale 1ns / 1ps
`include "ideal_mhd_flux_2d_assert.svh"

module ideal_mhd_flux_2d
    import imhd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // density, momentum_x, momentum_y, momentum_z, total_energy,
    // field_x, field_y, field_z (32 bits each, from bit 0 up)
    input  logic [255:0] s_tdata,
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // mass_flux, momx_flux, momy_flux, momz_flux, energy_flux,
    // fieldx_flux, fieldy_flux, fieldz_flux (32 bits each, from bit 0 up)
    output logic [255:0] m_tdata,
    // direction [0], status [2:1]
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    // Configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int NSTG = QUO_BITS / DIV_STEPS;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [17:0] r_gamma;
    logic signed [31:0] w_gm1;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {14'd0, r_gamma} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= GAMMA_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_gamma <= pwdata[17:0];
        end
    end

    assign w_gm1 = $signed({14'd0, r_gamma}) - (32'sd1 <<< FRAC_BITS);

    // ------------------------------------------------------------------
    // Global advance: every stage moves when the output stage can take a point.
    // ------------------------------------------------------------------
    logic r_o_vld;
    logic r_phase;
    logic w_adv;

    assign w_adv    = !r_o_vld || (m_tready && r_phase);
    assign s_tready = w_adv;

    // ------------------------------------------------------------------
    // Divider stages with the point's other values beside them
    // ------------------------------------------------------------------
    t_side w_in_side;
    t_qs   w_q1, w_q2, w_q3;
    t_side r_dside [NSTG+1];
    logic  r_dvld  [NSTG+1];

    always_comb begin
        w_in_side.rho    = s_tdata[31:0];
        w_in_side.energy = s_tdata[159:128];
        w_in_side.b1     = s_tdata[191:160];
        w_in_side.b2     = s_tdata[223:192];
        w_in_side.b3     = s_tdata[255:224];
        w_in_side.nonpos = (s_tdata[31] || (s_tdata[31:0] == 32'd0));
    end

    imhd_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .i_clk (i_clk), .i_en (w_adv),
        .i_num (s_tdata[63:32]), .i_den (s_tdata[31:0]), .o_quo (w_q1)
    );
    imhd_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .i_clk (i_clk), .i_en (w_adv),
        .i_num (s_tdata[95:64]), .i_den (s_tdata[31:0]), .o_quo (w_q2)
    );
    imhd_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
        .i_clk (i_clk), .i_en (w_adv),
        .i_num (s_tdata[127:96]), .i_den (s_tdata[31:0]), .o_quo (w_q3)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dside[0] <= w_in_side;
            for (int k = 1; k <= NSTG; k++) begin
                r_dside[k] <= r_dside[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NSTG; k++) begin
                r_dvld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_dvld[0] <= s_tvalid;
            for (int k = 1; k <= NSTG; k++) begin
                r_dvld[k] <= r_dvld[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: velocities
    // ------------------------------------------------------------------
    logic r_a_vld, r_a_sat;
    t_side r_a_side;
    logic signed [31:0] r_a_u1, r_a_u2, r_a_u3;

    // ------------------------------------------------------------------
    // Stage B: all products of velocities, field and density
    // ------------------------------------------------------------------
    logic r_b_vld, r_b_sat, n_b_sat;
    t_side r_b_side;
    logic signed [31:0] r_b_u1, r_b_u2, r_b_u3;
    logic signed [31:0] r_b_uu1, r_b_uu2, r_b_uu3, n_b_uu1, n_b_uu2, n_b_uu3;
    logic signed [31:0] r_b_bb11, r_b_bb22, r_b_bb33, n_b_bb11, n_b_bb22, n_b_bb33;
    logic signed [31:0] r_b_bb12, r_b_bb13, r_b_bb23, n_b_bb12, n_b_bb13, n_b_bb23;
    logic signed [31:0] r_b_p1, r_b_p2, n_b_p1, n_b_p2;
    logic signed [31:0] r_b_ub11, r_b_ub22, r_b_ub33, n_b_ub11, n_b_ub22, n_b_ub33;
    logic signed [31:0] r_b_ub12, r_b_ub21, r_b_ub13, n_b_ub12, n_b_ub21, n_b_ub13;
    logic signed [31:0] r_b_ub31, r_b_ub23, r_b_ub32, n_b_ub31, n_b_ub23, n_b_ub32;

    always_comb begin
        t_qs t;
        n_b_sat = r_a_sat;
        t = f_mul(r_a_u1, r_a_u1, FRAC_BITS); n_b_uu1 = t.v; n_b_sat |= t.sat;
        t = f_mul(r_a_u2, r_a_u2, FRAC_BITS); n_b_uu2 = t.v; n_b_sat |= t.sat;
        t = f_mul(r_a_u3, r_a_u3, FRAC_BITS); n_b_uu3 = t.v; n_b_sat |= t.sat;
        t = f_mul(r_a_side.b1, r_a_side.b1, FRAC_BITS); n_b_bb11 = t.v; n_b_sat |= t.sat;
        t = f_mul(r_a_side.b2, r_a_side.b2, FRAC_BITS); n_b_bb22 = t.v; n_b_sat |= t.sat;
        t = f_mul(r_a_side.b3, r_a_side.b3, FRAC_BITS); n_b_bb33 = t.v; n_b_sat |= t.sat;
        t = f_mul(r_a_side.b1, r_a_side.b2, FRAC_BITS); n_b_bb12 = t.v; n_b_sat |= t.sat;
        t = f_mul(r_a_side.b1, r_a_side.b3, FRAC_BITS); n_b_bb13 = t.v; n_b_sat |= t.sat;
        t = f_mul(r_a_side.b2, r_a_side.b3, FRAC_BITS); n_b_bb23 = t.v; n_b_sat |= t.sat;
        t = f_mul(r_a_side.rho, r_a_u1, FRAC_BITS); n_b_p1 = t.v; n_b_sat |= t.sat;
        t = f_mul(r_a_side.rho, r_a_u2, FRAC_BITS); n_b_p2 = t.v; n_b_sat |= t.sat;
        t = f_mul(r_a_u1, r_a_side.b1, FRAC_BITS); n_b_ub11 = t.v; n_b_sat |= t.sat;
        t = f_mul(r_a_u2, r_a_side.b2, FRAC_BITS); n_b_ub22 = t.v; n_b_sat |= t.sat;
        t = f_mul(r_a_u3, r_a_side.b3, FRAC_BITS); n_b_ub33 = t.v; n_b_sat |= t.sat;
        t = f_mul(r_a_u1, r_a_side.b2, FRAC_BITS); n_b_ub12 = t.v; n_b_sat |= t.sat;
        t = f_mul(r_a_u2, r_a_side.b1, FRAC_BITS); n_b_ub21 = t.v; n_b_sat |= t.sat;
        t = f_mul(r_a_u1, r_a_side.b3, FRAC_BITS); n_b_ub13 = t.v; n_b_sat |= t.sat;
        t = f_mul(r_a_u3, r_a_side.b1, FRAC_BITS); n_b_ub31 = t.v; n_b_sat |= t.sat;
        t = f_mul(r_a_u2, r_a_side.b3, FRAC_BITS); n_b_ub23 = t.v; n_b_sat |= t.sat;
        t = f_mul(r_a_u3, r_a_side.b2, FRAC_BITS); n_b_ub32 = t.v; n_b_sat |= t.sat;
    end

    // ------------------------------------------------------------------
    // Stage C: squared sums, field-velocity sum, momentum-velocity products,
    // and the induction fluxes
    // ------------------------------------------------------------------
    logic r_c_vld, r_c_sat, n_c_sat;
    t_side r_c_side;
    t_flux r_c_flux, n_c_flux;
    logic signed [31:0] r_c_u1, r_c_u2;
    logic signed [31:0] r_c_usq, r_c_bsq, r_c_bu, n_c_usq, n_c_bsq, n_c_bu;
    logic signed [31:0] r_c_pu11, r_c_pu12, r_c_pu13, n_c_pu11, n_c_pu12, n_c_pu13;
    logic signed [31:0] r_c_pu22, r_c_pu23, n_c_pu22, n_c_pu23;
    logic signed [31:0] r_c_bb11, r_c_bb22, r_c_bb12, r_c_bb13, r_c_bb23;

    always_comb begin
        t_qs t;
        n_c_sat  = r_b_sat;
        n_c_flux = '0;
        t = f_add(r_b_uu1, r_b_uu2); n_c_sat |= t.sat;
        t = f_add(t.v, r_b_uu3);     n_c_usq = t.v; n_c_sat |= t.sat;
        t = f_add(r_b_bb11, r_b_bb22); n_c_sat |= t.sat;
        t = f_add(t.v, r_b_bb33);      n_c_bsq = t.v; n_c_sat |= t.sat;
        t = f_add(r_b_ub11, r_b_ub22); n_c_sat |= t.sat;
        t = f_add(t.v, r_b_ub33);      n_c_bu = t.v; n_c_sat |= t.sat;
        t = f_mul(r_b_p1, r_b_u1, FRAC_BITS); n_c_pu11 = t.v; n_c_sat |= t.sat;
        t = f_mul(r_b_p1, r_b_u2, FRAC_BITS); n_c_pu12 = t.v; n_c_sat |= t.sat;
        t = f_mul(r_b_p1, r_b_u3, FRAC_BITS); n_c_pu13 = t.v; n_c_sat |= t.sat;
        t = f_mul(r_b_p2, r_b_u2, FRAC_BITS); n_c_pu22 = t.v; n_c_sat |= t.sat;
        t = f_mul(r_b_p2, r_b_u3, FRAC_BITS); n_c_pu23 = t.v; n_c_sat |= t.sat;
        n_c_flux.fx[0] = r_b_p1;
        n_c_flux.fy[0] = r_b_p2;
        t = f_sub(r_b_ub12, r_b_ub21); n_c_flux.fx[6] = t.v; n_c_sat |= t.sat;
        t = f_sub(r_b_ub13, r_b_ub31); n_c_flux.fx[7] = t.v; n_c_sat |= t.sat;
        t = f_sub(r_b_ub21, r_b_ub12); n_c_flux.fy[5] = t.v; n_c_sat |= t.sat;
        t = f_sub(r_b_ub23, r_b_ub32); n_c_flux.fy[7] = t.v; n_c_sat |= t.sat;
    end

    // ------------------------------------------------------------------
    // Stage D: magnetic pressure, density times speed squared, field times
    // field-velocity sum, and the transverse momentum fluxes
    // ------------------------------------------------------------------
    logic r_d_vld, r_d_sat, n_d_sat;
    t_side r_d_side;
    t_flux r_d_flux, n_d_flux;
    logic signed [31:0] r_d_u1, r_d_u2;
    logic signed [31:0] r_d_bm, r_d_rus, n_d_rus;
    logic signed [31:0] r_d_b1bu, r_d_b2bu, n_d_b1bu, n_d_b2bu;
    logic signed [31:0] r_d_pu11, r_d_pu22, r_d_bb11, r_d_bb22;

    always_comb begin
        t_qs t;
        n_d_sat  = r_c_sat;
        n_d_flux = r_c_flux;
        t = f_mul(r_c_side.rho, r_c_usq, FRAC_BITS); n_d_rus = t.v; n_d_sat |= t.sat;
        t = f_mul(r_c_side.b1, r_c_bu, FRAC_BITS); n_d_b1bu = t.v; n_d_sat |= t.sat;
        t = f_mul(r_c_side.b2, r_c_bu, FRAC_BITS); n_d_b2bu = t.v; n_d_sat |= t.sat;
        t = f_sub(r_c_pu12, r_c_bb12); n_d_sat |= t.sat;
        n_d_flux.fx[2] = t.v;
        n_d_flux.fy[1] = t.v;
        t = f_sub(r_c_pu13, r_c_bb13); n_d_flux.fx[3] = t.v; n_d_sat |= t.sat;
        t = f_sub(r_c_pu23, r_c_bb23); n_d_flux.fy[3] = t.v; n_d_sat |= t.sat;
    end

    // ------------------------------------------------------------------
    // Stage E: internal energy term E - ke - bm
    // ------------------------------------------------------------------
    logic r_e_vld, r_e_sat, n_e_sat;
    t_side r_e_side;
    t_flux r_e_flux;
    logic signed [31:0] r_e_u1, r_e_u2, r_e_bm, r_e_tdiff, n_e_tdiff;
    logic signed [31:0] r_e_b1bu, r_e_b2bu, r_e_pu11, r_e_pu22, r_e_bb11, r_e_bb22;

    always_comb begin
        t_qs t;
        n_e_sat = r_d_sat;
        t = f_sub(r_d_side.energy, f_half(r_d_rus)); n_e_sat |= t.sat;
        t = f_sub(t.v, r_d_bm); n_e_tdiff = t.v; n_e_sat |= t.sat;
    end

    // ------------------------------------------------------------------
    // Stage F: gas pressure
    // ------------------------------------------------------------------
    logic r_f_vld, r_f_sat, n_f_sat;
    t_side r_f_side;
    t_flux r_f_flux;
    logic signed [31:0] r_f_u1, r_f_u2, r_f_bm, r_f_press, n_f_press;
    logic signed [31:0] r_f_b1bu, r_f_b2bu, r_f_pu11, r_f_pu22, r_f_bb11, r_f_bb22;

    always_comb begin
        t_qs t;
        t = f_mul(w_gm1, r_e_tdiff, FRAC_BITS);
        n_f_press = t.v;
        n_f_sat   = r_e_sat | t.sat;
    end

    // ------------------------------------------------------------------
    // Stage G: total energy plus pressures, and the normal momentum fluxes
    // ------------------------------------------------------------------
    logic r_g_vld, r_g_sat, n_g_sat;
    t_side r_g_side;
    t_flux r_g_flux, n_g_flux;
    logic signed [31:0] r_g_u1, r_g_u2, r_g_etot, n_g_etot, r_g_b1bu, r_g_b2bu;

    always_comb begin
        t_qs t;
        n_g_sat  = r_f_sat;
        n_g_flux = r_f_flux;
        t = f_add(r_f_side.energy, r_f_press); n_g_sat |= t.sat;
        t = f_add(t.v, r_f_bm); n_g_etot = t.v; n_g_sat |= t.sat;
        t = f_add(r_f_pu11, r_f_press); n_g_sat |= t.sat;
        t = f_add(t.v, r_f_bm); n_g_sat |= t.sat;
        t = f_sub(t.v, r_f_bb11); n_g_flux.fx[1] = t.v; n_g_sat |= t.sat;
        t = f_add(r_f_pu22, r_f_press); n_g_sat |= t.sat;
        t = f_add(t.v, r_f_bm); n_g_sat |= t.sat;
        t = f_sub(t.v, r_f_bb22); n_g_flux.fy[2] = t.v; n_g_sat |= t.sat;
    end

    // ------------------------------------------------------------------
    // Stage H: velocity times total energy term
    // ------------------------------------------------------------------
    logic r_h_vld, r_h_sat, n_h_sat;
    t_side r_h_side;
    t_flux r_h_flux;
    logic signed [31:0] r_h_ue1, r_h_ue2, n_h_ue1, n_h_ue2, r_h_b1bu, r_h_b2bu;

    always_comb begin
        t_qs t;
        n_h_sat = r_g_sat;
        t = f_mul(r_g_u1, r_g_etot, FRAC_BITS); n_h_ue1 = t.v; n_h_sat |= t.sat;
        t = f_mul(r_g_u2, r_g_etot, FRAC_BITS); n_h_ue2 = t.v; n_h_sat |= t.sat;
    end

    // ------------------------------------------------------------------
    // Output stage: energy fluxes, status, zeroing for nonpositive density
    // ------------------------------------------------------------------
    t_flux r_o_flux, n_o_flux;
    logic [1:0] r_o_status, n_o_status;

    always_comb begin
        t_qs t;
        logic sat;
        n_o_flux = r_h_flux;
        sat = r_h_sat;
        t = f_sub(r_h_ue1, r_h_b1bu); n_o_flux.fx[4] = t.v; sat |= t.sat;
        t = f_sub(r_h_ue2, r_h_b2bu); n_o_flux.fy[4] = t.v; sat |= t.sat;
        n_o_flux.fx[5] = '0;
        n_o_flux.fy[6] = '0;
        if (r_h_side.nonpos) begin
            n_o_flux   = '0;
            n_o_status = ST_NONPOS;
        end else begin
            n_o_status = sat ? ST_SAT : ST_OK;
        end
    end

    // Payload registers of all arithmetic stages.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_sat  <= w_q1.sat | w_q2.sat | w_q3.sat;
            r_a_side <= r_dside[NSTG];
            r_a_u1   <= w_q1.v;
            r_a_u2   <= w_q2.v;
            r_a_u3   <= w_q3.v;

            r_b_sat  <= n_b_sat;
            r_b_side <= r_a_side;
            r_b_u1   <= r_a_u1;
            r_b_u2   <= r_a_u2;
            r_b_u3   <= r_a_u3;
            r_b_uu1  <= n_b_uu1;
            r_b_uu2  <= n_b_uu2;
            r_b_uu3  <= n_b_uu3;
            r_b_bb11 <= n_b_bb11;
            r_b_bb22 <= n_b_bb22;
            r_b_bb33 <= n_b_bb33;
            r_b_bb12 <= n_b_bb12;
            r_b_bb13 <= n_b_bb13;
            r_b_bb23 <= n_b_bb23;
            r_b_p1   <= n_b_p1;
            r_b_p2   <= n_b_p2;
            r_b_ub11 <= n_b_ub11;
            r_b_ub22 <= n_b_ub22;
            r_b_ub33 <= n_b_ub33;
            r_b_ub12 <= n_b_ub12;
            r_b_ub21 <= n_b_ub21;
            r_b_ub13 <= n_b_ub13;
            r_b_ub31 <= n_b_ub31;
            r_b_ub23 <= n_b_ub23;
            r_b_ub32 <= n_b_ub32;

            r_c_sat  <= n_c_sat;
            r_c_side <= r_b_side;
            r_c_flux <= n_c_flux;
            r_c_u1   <= r_b_u1;
            r_c_u2   <= r_b_u2;
            r_c_usq  <= n_c_usq;
            r_c_bsq  <= n_c_bsq;
            r_c_bu   <= n_c_bu;
            r_c_pu11 <= n_c_pu11;
            r_c_pu12 <= n_c_pu12;
            r_c_pu13 <= n_c_pu13;
            r_c_pu22 <= n_c_pu22;
            r_c_pu23 <= n_c_pu23;
            r_c_bb11 <= r_b_bb11;
            r_c_bb22 <= r_b_bb22;
            r_c_bb12 <= r_b_bb12;
            r_c_bb13 <= r_b_bb13;
            r_c_bb23 <= r_b_bb23;

            r_d_sat  <= n_d_sat;
            r_d_side <= r_c_side;
            r_d_flux <= n_d_flux;
            r_d_u1   <= r_c_u1;
            r_d_u2   <= r_c_u2;
            r_d_bm   <= f_half(r_c_bsq);
            r_d_rus  <= n_d_rus;
            r_d_b1bu <= n_d_b1bu;
            r_d_b2bu <= n_d_b2bu;
            r_d_pu11 <= r_c_pu11;
            r_d_pu22 <= r_c_pu22;
            r_d_bb11 <= r_c_bb11;
            r_d_bb22 <= r_c_bb22;

            r_e_sat   <= n_e_sat;
            r_e_side  <= r_d_side;
            r_e_flux  <= r_d_flux;
            r_e_u1    <= r_d_u1;
            r_e_u2    <= r_d_u2;
            r_e_bm    <= r_d_bm;
            r_e_tdiff <= n_e_tdiff;
            r_e_b1bu  <= r_d_b1bu;
            r_e_b2bu  <= r_d_b2bu;
            r_e_pu11  <= r_d_pu11;
            r_e_pu22  <= r_d_pu22;
            r_e_bb11  <= r_d_bb11;
            r_e_bb22  <= r_d_bb22;

            r_f_sat   <= n_f_sat;
            r_f_side  <= r_e_side;
            r_f_flux  <= r_e_flux;
            r_f_u1    <= r_e_u1;
            r_f_u2    <= r_e_u2;
            r_f_bm    <= r_e_bm;
            r_f_press <= n_f_press;
            r_f_b1bu  <= r_e_b1bu;
            r_f_b2bu  <= r_e_b2bu;
            r_f_pu11  <= r_e_pu11;
            r_f_pu22  <= r_e_pu22;
            r_f_bb11  <= r_e_bb11;
            r_f_bb22  <= r_e_bb22;

            r_g_sat  <= n_g_sat;
            r_g_side <= r_f_side;
            r_g_flux <= n_g_flux;
            r_g_u1   <= r_f_u1;
            r_g_u2   <= r_f_u2;
            r_g_etot <= n_g_etot;
            r_g_b1bu <= r_f_b1bu;
            r_g_b2bu <= r_f_b2bu;

            r_h_sat  <= n_h_sat;
            r_h_side <= r_g_side;
            r_h_flux <= r_g_flux;
            r_h_ue1  <= n_h_ue1;
            r_h_ue2  <= n_h_ue2;
            r_h_b1bu <= r_g_b1bu;
            r_h_b2bu <= r_g_b2bu;

            r_o_flux   <= n_o_flux;
            r_o_status <= n_o_status;
        end
    end

    // Valid bits of the arithmetic stages and the output phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
            r_o_vld <= 1'b0;
            r_phase <= DIR_X;
        end else begin
            if (w_adv) begin
                r_a_vld <= r_dvld[NSTG];
                r_b_vld <= r_a_vld;
                r_c_vld <= r_b_vld;
                r_d_vld <= r_c_vld;
                r_e_vld <= r_d_vld;
                r_f_vld <= r_e_vld;
                r_g_vld <= r_f_vld;
                r_h_vld <= r_g_vld;
                r_o_vld <= r_h_vld;
            end
            // The x result goes first; the y result closes the point.
            if (r_o_vld && m_tready) begin
                r_phase <= (r_phase == DIR_X) ? DIR_Y : DIR_X;
            end
        end
    end

    // Result stream
    assign m_tvalid = r_o_vld;
    assign m_tlast  = (r_phase == DIR_Y);
    assign m_tuser  = {r_o_status, r_phase};
    assign m_tdata  = (r_phase == DIR_Y) ? r_o_flux.fy : r_o_flux.fx;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `IMHD_ASSERT(a_stall_blocks_input, i_clk, i_rst_n, (m_tvalid && !m_tready) |-> !s_tready)
    `IMHD_ASSERT(a_y_follows_x, i_clk, i_rst_n,
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast))
    `IMHD_ASSERT(a_nonpos_zero, i_clk, i_rst_n,
        (m_tvalid && (m_tuser[2:1] == ST_NONPOS)) |-> (m_tdata == 256'd0))
    `IMHD_ASSERT(a_x_fieldx_zero, i_clk, i_rst_n,
        (m_tvalid && !m_tlast) |-> (m_tdata[191:160] == 32'd0))
    `IMHD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_tvalid)

endmodule

### rtl/imhd_div.sv
// Pipelined signed fixed-point divider: (num << FRAC_BITS) / den, truncated, clamped.
// Depends on imhd_pkg; the caller supplies one advance enable for all stages.
`timescale 1ns / 1ps

module imhd_div
    import imhd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output t_qs                o_quo
);

    localparam int NSTG = QUO_BITS / DIV_STEPS;

    logic [31:0] r_rem [NSTG+1];
    logic [31:0] r_q   [NSTG+1];
    logic [31:0] r_den [NSTG+1];
    logic        r_neg [NSTG+1];
    logic        r_big [NSTG+1];

    // Split the scaled magnitude: the high part decides overflow, the low part
    // feeds the 32 quotient steps.
    logic [31:0]             w_mag;
    logic [31+FRAC_BITS:0]   w_dvd;
    logic [FRAC_BITS-1:0]    w_hi;
    logic                    w_big;

    always_comb begin
        w_mag = i_num[31] ? (32'd0 - i_num) : i_num;
        w_dvd = {w_mag, {FRAC_BITS{1'b0}}};
        w_hi  = w_dvd[31+FRAC_BITS:32];
        w_big = (32'(w_hi) >= i_den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_big ? 32'd0 : 32'(w_hi);
            r_q[0]   <= w_dvd[31:0];
            r_den[0] <= i_den;
            r_neg[0] <= i_num[31];
            r_big[0] <= w_big;
        end
    end

    // Each stage resolves DIV_STEPS quotient bits by restoring subtraction.
    for (genvar k = 1; k <= NSTG; k++) begin : g_stage
        logic [31:0] n_rem;
        logic [31:0] n_q;

        always_comb begin
            logic [32:0] rem2;
            n_rem = r_rem[k-1];
            n_q   = r_q[k-1];
            rem2  = '0;
            for (int j = 0; j < DIV_STEPS; j++) begin
                rem2 = {n_rem, n_q[31]};
                if (rem2 >= {1'b0, r_den[k-1]}) begin
                    rem2 = rem2 - {1'b0, r_den[k-1]};
                    n_q  = {n_q[30:0], 1'b1};
                end else begin
                    n_q  = {n_q[30:0], 1'b0};
                end
                n_rem = rem2[31:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_q[k]   <= n_q;
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
                r_big[k] <= r_big[k-1];
            end
        end
    end

    // Apply the sign and clamp to the signed 32-bit range.
    always_comb begin
        if (r_big[NSTG]) begin
            o_quo.sat = 1'b1;
            o_quo.v   = r_neg[NSTG] ? Q_MIN : Q_MAX;
        end else if (r_neg[NSTG]) begin
            o_quo.sat = (r_q[NSTG] > 32'h8000_0000);
            o_quo.v   = o_quo.sat ? Q_MIN : (32'd0 - r_q[NSTG]);
        end else begin
            o_quo.sat = (r_q[NSTG] > 32'h7fff_ffff);
            o_quo.v   = o_quo.sat ? Q_MAX : r_q[NSTG];
        end
    end

endmodule

### verif/tb.sv
// Self-checking testbench for the ideal_mhd_flux_2d pipeline.
// Depends on imhd_pkg and the RTL; predicts both flux results per point in fixed point.
`timescale 1ns / 1ps

module tb;
    import imhd_pkg::*;

    localparam int FRAC = 16;

    typedef struct packed {
        logic             dir;
        logic             last;
        logic [7:0][31:0] flux;
        logic [1:0]       st;
    } t_flux_res;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // density, momentum_x, momentum_y, momentum_z, total_energy,
    // field_x, field_y, field_z (32 bits each, from bit 0 up)
    logic [255:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // mass_flux, momx..momz_flux, energy_flux, fieldx..fieldz_flux
    logic [255:0] m_tdata;
    // direction [0], status [2:1]
    logic [2:0]   m_tuser;
    logic         m_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    ideal_mhd_flux_2d DUT (.*);

    always #2 i_clk = ~i_clk;

    t_flux_res   flux_expected[$];
    logic [17:0] gamma_q;
    bit          sat_seen;
    int          mismatches;
    bit          rx_idle_on;
    int          rx_hold;
    int          long_hold;

    // Fixed-point helpers that mirror the block's arithmetic rules.
    function automatic longint clamp_q(longint v);
        if (v > 64'sd2147483647) begin
            sat_seen = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat_seen = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint qm(longint a, longint b);
        longint p;
        p = a * b;
        return clamp_q(p >>> FRAC);
    endfunction

    function automatic longint qa(longint a, longint b);
        return clamp_q(a + b);
    endfunction

    function automatic longint qs(longint a, longint b);
        return clamp_q(a - b);
    endfunction

    // Work out the x and y flux results of one grid point.
    task automatic predict_fluxes(input logic [255:0] pt);
        longint rho, en, b1, b2, b3, u1, u2, u3, usq, bsq, bm, ke, gm1;
        longint press, bu, p1, p2, etot;
        longint fx[8], fy[8];
        t_flux_res r;
        logic [1:0] st;
        rho = longint'($signed(pt[31:0]));
        en  = longint'($signed(pt[159:128]));
        b1  = longint'($signed(pt[191:160]));
        b2  = longint'($signed(pt[223:192]));
        b3  = longint'($signed(pt[255:224]));
        sat_seen = 1'b0;
        for (int j = 0; j < 8; j++) begin
            fx[j] = 0;
            fy[j] = 0;
        end
        if (rho <= 0) begin
            st = ST_NONPOS;
        end else begin
            u1 = clamp_q((longint'($signed(pt[63:32])) * 65536) / rho);
            u2 = clamp_q((longint'($signed(pt[95:64])) * 65536) / rho);
            u3 = clamp_q((longint'($signed(pt[127:96])) * 65536) / rho);
            usq = qa(qa(qm(u1, u1), qm(u2, u2)), qm(u3, u3));
            bsq = qa(qa(qm(b1, b1), qm(b2, b2)), qm(b3, b3));
            bm = bsq >>> 1;
            ke = qm(rho, usq) >>> 1;
            gm1 = longint'(gamma_q) - 65536;
            press = qm(gm1, qs(qs(en, ke), bm));
            bu = qa(qa(qm(u1, b1), qm(u2, b2)), qm(u3, b3));
            p1 = qm(rho, u1);
            p2 = qm(rho, u2);
            etot = qa(qa(en, press), bm);
            fx[0] = p1;
            fx[1] = qs(qa(qa(qm(p1, u1), press), bm), qm(b1, b1));
            fx[2] = qs(qm(p1, u2), qm(b1, b2));
            fx[3] = qs(qm(p1, u3), qm(b1, b3));
            fx[4] = qs(qm(u1, etot), qm(b1, bu));
            fx[6] = qs(qm(u1, b2), qm(u2, b1));
            fx[7] = qs(qm(u1, b3), qm(u3, b1));
            fy[0] = p2;
            fy[1] = qs(qm(p1, u2), qm(b2, b1));
            fy[2] = qs(qa(qa(qm(p2, u2), press), bm), qm(b2, b2));
            fy[3] = qs(qm(p2, u3), qm(b2, b3));
            fy[4] = qs(qm(u2, etot), qm(b2, bu));
            fy[5] = qs(qm(u2, b1), qm(u1, b2));
            fy[7] = qs(qm(u2, b3), qm(u3, b2));
            st = sat_seen ? ST_SAT : ST_OK;
        end
        r.dir = DIR_X;
        r.last = 1'b0;
        r.st = st;
        for (int j = 0; j < 8; j++) r.flux[j] = fx[j][31:0];
        flux_expected.push_back(r);
        r.dir = DIR_Y;
        r.last = 1'b1;
        for (int j = 0; j < 8; j++) r.flux[j] = fy[j][31:0];
        flux_expected.push_back(r);
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one grid point and wait for its transfer.
    task automatic send_point(input logic [255:0] pt);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= pt;
        do @(posedge i_clk); while (!s_tready);
        predict_fluxes(pt);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [255:0] pack_point(int rho, int mx, int my, int mz,
                                                int en, int bx, int by, int bz);
        return {bz, by, bx, en, mz, my, mx, rho};
    endfunction

    // A physically sensible point with random content.
    function automatic logic [255:0] sane_point();
        return pack_point($urandom_range(1 << 12, 1 << 20),
                          $signed($urandom_range(0, 1 << 21)) - (1 << 20),
                          $signed($urandom_range(0, 1 << 21)) - (1 << 20),
                          $signed($urandom_range(0, 1 << 21)) - (1 << 20),
                          $urandom_range(0, 1 << 22),
                          $signed($urandom_range(0, 1 << 19)) - (1 << 18),
                          $signed($urandom_range(0, 1 << 19)) - (1 << 18),
                          $signed($urandom_range(0, 1 << 19)) - (1 << 18));
    endfunction

    function automatic logic [255:0] noise_point();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    // Wait until every result is in, then let the pipeline settle.
    task automatic drain();
        stop_sending();
        while (flux_expected.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == 3'd0) gamma_q = val[17:0];
    endtask

    // Extremes, nonpositive density and saturating points.
    task automatic test_directed();
        send_point(pack_point(0, 1, 2, 3, 4, 5, 6, 7));
        send_point(pack_point(-65536, 65536, 0, 0, 65536, 0, 0, 0));
        send_point(pack_point(32'h8000_0000, -1, -1, -1, -1, -1, -1, -1));
        send_point(pack_point(65536, 0, 0, 0, 0, 0, 0, 0));
        send_point(pack_point(65536, 65536, 131072, -65536, 655360, 32768, -32768, 65536));
        send_point(pack_point(1, 32'h7fff_ffff, 32'h8000_0000, 1, 0, 0, 0, 0));
        send_point(pack_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_point(pack_point(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_point(pack_point(65536, -32'sd655360, 327680, 0, -32'sd65536,
                              1 << 24, -(1 << 24), 1 << 23));
        send_point(pack_point(1, 0, 0, 0, 32'h8000_0000, 0, 0, 0));
        send_point(pack_point(256, 512, -512, 1024, 1 << 20, 1 << 16, 1 << 16, 1 << 16));
        repeat (8) send_point(sane_point());
        drain();
    endtask

    // Random points, mostly well formed, with receiver stalls in the first half only.
    task automatic test_random(input int count);
        rx_idle_on = 1'b1;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) rx_idle_on = 1'b0;
            if ($urandom_range(0, 9) < 8) send_point(sane_point());
            else send_point(noise_point());
        end
        rx_idle_on = 1'b1;
        drain();
    endtask

    // Receiver holds off for a long stretch while points keep coming.
    task automatic test_backpressure();
        long_hold = 300;
        for (int i = 0; i < 40; i++) send_point(sane_point());
        drain();
    endtask

    // Gamma settings: limits, zero and negative gamma - 1, and an ignored address.
    task automatic test_gamma_settings();
        logic [31:0] gammas[6];
        gammas = '{32'd65537, 32'd196608, 32'd65536, 32'd0, 32'h3_ffff, 32'd131072};
        foreach (gammas[k]) begin
            write_reg(3'd0, gammas[k]);
            test_random(80);
        end
        write_reg(3'd4, 32'd70000);
        test_random(40);
    endtask

    // Receiver ready: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (long_hold > 0) begin
            m_tready  <= 1'b0;
            long_hold <= long_hold - 1;
        end else if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
            m_tready <= 1'b0;
            rx_hold  <= ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2)
                                                  : $urandom_range(10, 40);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare every result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_flux_res exp_r;
        bit bad;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (flux_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result transfer: %h", m_tdata);
            end else begin
                exp_r = flux_expected.pop_front();
                bad = (m_tuser[0] !== exp_r.dir) || (m_tlast !== exp_r.last)
                      || (m_tuser[2:1] !== exp_r.st);
                for (int j = 0; j < 8; j++)
                    if (m_tdata[32*j +: 32] !== exp_r.flux[j]) bad = 1'b1;
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: exp dir %0d last %0b st %0d flux %h / got dir %0d last %0b st %0d flux %h",
                                 exp_r.dir, exp_r.last, exp_r.st, exp_r.flux,
                                 m_tuser[0], m_tlast, m_tuser[2:1], m_tdata);
                end
            end
        end
    end

    initial begin
        gamma_q = GAMMA_RESET;
        mismatches = 0;
        rx_idle_on = 1'b1;
        rx_hold = 0;
        long_hold = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);
        test_directed();
        test_random(300);
        test_backpressure();
        test_gamma_settings();
        write_reg(3'd0, 32'd109227);
        test_random(80);
        if (mismatches == 0 && flux_expected.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
